/* hdl/pdst_pkg.sv */
package pdst_pkg;

   // Microseconds in one second
   localparam int unsigned USEC_PER_SEC = 1000000;

   // Reset value of the lost-sample threshold register
   localparam logic [15:0] LOST_THRESHOLD_RESET = 16'd54;

   // Saturation limit of the per-second sample counter
   localparam logic [15:0] SAMPLES_MAX = 16'hFFFF;

   // Result classification
   typedef enum logic [1:0] {
      EVENT_SAMPLE     = 2'd0,
      EVENT_PPS        = 2'd1,
      EVENT_SUPPRESSED = 2'd2,
      EVENT_UNKNOWN    = 2'd3
   } event_kind_type;

endpackage

/* hdl/pps_disciplined_sample_timestamper_top.sv */
// PPS-disciplined sample timestamper.
// Request channel (req_*): one interrupt event per transaction, carrying the
// ADC-ready and PPS pending bits, the FPGA-busy flag and the current time.
// ADC-ready wins when both pending bits are set.
// Response channel (rsp_*): exactly one result transaction per request, in
// order: event kind, sample timestamp, sample index, lost-sample and time
// error flags, mux select level and watchdog kick.
// csr_write_enable/csr_write_data write the 16-bit lost-sample threshold.
// Structure: two register stages (request register, result register) lie
// between req_* and rsp_*.
// Throughput: one transaction per cycle while the receiver does not stall; the
// result path is one 32x20 constant multiply and one add between the registers.
// Reset (synchronous, active high) empties both stages, clears all timing
// state and counters and sets the threshold to 54.
// When the receiver stalls, the result register holds; the request register
// still takes a transaction while it is empty, then req_stall rises until the
// result register drains.
module pps_disciplined_sample_timestamper_top
   import pdst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_adc_ready_pending,
   input  logic        req_pps_pending,
   input  logic        req_fpga_busy,
   input  logic [31:0] req_current_sec,
   input  logic [19:0] req_current_usec,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic [51:0] rsp_timestamp_usec,
   output logic [31:0] rsp_sample_index,
   output logic        rsp_lost_samples,
   output logic        rsp_time_error,
   output logic        rsp_mux_select,
   output logic        rsp_watchdog_kick,
   // configuration
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   // request register
   logic        req_valid_ff;
   logic        adc_ff, pps_ff, busy_ff;
   logic [31:0] sec_ff;
   logic [19:0] usec_ff;

   // block state
   logic [15:0] threshold_ff;
   logic [31:0] anchor_sec_ff,   anchor_sec_in;
   logic [19:0] anchor_usec_ff,  anchor_usec_in;
   logic [31:0] elapsed_sec_ff,  elapsed_sec_in;
   logic [31:0] sample_count_ff, sample_count_in;
   logic [15:0] samples_sec_ff,  samples_sec_in;
   logic        mux_ff,          mux_in;

   // result register
   logic           rsp_valid_ff;
   event_kind_type kind_ff,  kind_in;
   logic [51:0]    ts_ff,    ts_in;
   logic [31:0]    index_ff;
   logic           lost_ff,  lost_in;
   logic           terr_ff,  terr_in;
   logic           mux_out_ff;
   logic           kick_ff,  kick_in;

   logic        advance;
   logic [22:0] diff_same;
   logic [22:0] diff_next;
   logic [20:0] micros;
   logic        in_same_sec, in_next_sec;

   // handshake: the request stage moves on whenever the result stage is free
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;

   // microseconds since the PPS base, clamped at zero when time runs backward
   assign in_same_sec = (sec_ff == anchor_sec_ff);
   assign in_next_sec = ((anchor_sec_ff + 32'd1) == sec_ff);
   assign diff_same   = {3'b000, usec_ff} - {3'b000, anchor_usec_ff};
   assign diff_next   = 23'(USEC_PER_SEC) + {3'b000, usec_ff} - {3'b000, anchor_usec_ff};

   always_comb begin
      if (in_same_sec) begin
         micros = diff_same[22] ? 21'd0 : diff_same[20:0];
      end else if (in_next_sec) begin
         micros = diff_next[22] ? 21'd0 : diff_next[20:0];
      end else begin
         micros = 21'd0;
      end
   end

   // event decode and next state
   always_comb begin
      anchor_sec_in   = anchor_sec_ff;
      anchor_usec_in  = anchor_usec_ff;
      elapsed_sec_in  = elapsed_sec_ff;
      sample_count_in = sample_count_ff;
      samples_sec_in  = samples_sec_ff;
      mux_in          = mux_ff;
      kind_in         = EVENT_UNKNOWN;
      ts_in           = 52'd0;
      lost_in         = 1'b0;
      terr_in         = 1'b0;
      kick_in         = 1'b0;
      if (adc_ff) begin
         if (samples_sec_ff != SAMPLES_MAX) begin
            samples_sec_in = samples_sec_ff + 16'd1;
         end
         terr_in         = !in_same_sec && !in_next_sec && (anchor_sec_ff != 32'd0);
         sample_count_in = sample_count_ff + 32'd1;
         if (busy_ff) begin
            kind_in = EVENT_SUPPRESSED;
         end else begin
            mux_in  = 1'b1;
            kind_in = EVENT_SAMPLE;
            ts_in   = 52'(elapsed_sec_ff) * 52'(USEC_PER_SEC) + 52'(micros);
         end
      end else if (pps_ff) begin
         anchor_sec_in  = sec_ff;
         anchor_usec_in = usec_ff;
         elapsed_sec_in = elapsed_sec_ff + 32'd1;
         lost_in        = (samples_sec_ff > threshold_ff);
         samples_sec_in = 16'd0;
         if (!busy_ff) begin
            mux_in  = 1'b0;
            kick_in = 1'b1;
         end
         kind_in = EVENT_PPS;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         adc_ff  <= req_adc_ready_pending;
         pps_ff  <= req_pps_pending;
         busy_ff <= req_fpga_busy;
         sec_ff  <= req_current_sec;
         usec_ff <= req_current_usec;
      end
   end

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= LOST_THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         threshold_ff <= csr_write_data;
      end
   end

   // state update, once per transaction as it enters the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_sec_ff   <= 32'd0;
         anchor_usec_ff  <= 20'd0;
         elapsed_sec_ff  <= 32'd0;
         sample_count_ff <= 32'd0;
         samples_sec_ff  <= 16'd0;
         mux_ff          <= 1'b0;
      end else if (advance) begin
         anchor_sec_ff   <= anchor_sec_in;
         anchor_usec_ff  <= anchor_usec_in;
         elapsed_sec_ff  <= elapsed_sec_in;
         sample_count_ff <= sample_count_in;
         samples_sec_ff  <= samples_sec_in;
         mux_ff          <= mux_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         kind_ff    <= kind_in;
         ts_ff      <= ts_in;
         index_ff   <= sample_count_in;
         lost_ff    <= lost_in;
         terr_ff    <= terr_in;
         mux_out_ff <= mux_in;
         kick_ff    <= kick_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_kind     = kind_ff;
   assign rsp_timestamp_usec = ts_ff;
   assign rsp_sample_index   = index_ff;
   assign rsp_lost_samples   = lost_ff;
   assign rsp_time_error     = terr_ff;
   assign rsp_mux_select     = mux_out_ff;
   assign rsp_watchdog_kick  = kick_ff;

endmodule
